/* src/csp_pkg.sv */
package csp_pkg;

    localparam int unsigned SENSOR_NUM  = 3;
    localparam int unsigned COUNT_W     = 12;
    localparam int unsigned PIN_W       = 4;
    localparam int unsigned DUTY_W      = 6;
    localparam int unsigned DBC_W       = 8;
    localparam int unsigned HIST_W      = 4;
    localparam int unsigned CNT32_W     = 32;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam logic [PIN_W-1:0]   PIN_FIRST = 4'd6;
    localparam logic [PIN_W-1:0]   PIN_LAST  = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

    // slider math constants
    localparam logic signed [13:0] POS_OFS_LEFT  = 14'sd10;
    localparam logic signed [13:0] POS_OFS_MID   = 14'sd30;
    localparam logic signed [13:0] POS_OFS_RIGHT = 14'sd50;
    localparam logic signed [13:0] POS_MAX_S     = 14'sd60;
    localparam logic [DUTY_W-1:0]  POS_MID       = 6'd30;
    localparam logic [6:0]         DUTY_FULL     = 7'd60;
    localparam logic [6:0]         DUTY_DOUBLE   = 7'd120;

    // reset values of the config registers
    localparam logic [COUNT_W-1:0] THRESH_RST  = 12'd2048;
    localparam logic               DBC_EN_RST  = 1'b1;
    localparam logic [DBC_W-1:0]   DBC_LIM_RST = 8'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_DBC_EN    = 2'd1,
        CFG_DBC_LIMIT = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_addr;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [DUTY_W-1:0]  t_duty;

    typedef struct packed {
        logic [COUNT_W-1:0] touch_level;
        logic               debounce_enable;
        logic [DBC_W-1:0]   debounce_limit;
    } t_cfg;

    typedef struct packed {
        logic               yes_touch;
        logic               no_touch;
        logic               timeout_flag;
        logic               overrun_flag;
        logic [PIN_W-1:0]   sensor_pin;
        logic [COUNT_W-1:0] sample_count;
    } t_in_item;

    typedef struct packed {
        logic               pwm_update;
        logic [DUTY_W-1:0]  duty_left;
        logic [DUTY_W-1:0]  duty_middle;
        logic [DUTY_W-1:0]  duty_right;
        logic [DUTY_W-1:0]  position;
        logic               position_valid;
        logic [CNT32_W-1:0] timeout_total;
        logic [CNT32_W-1:0] overrun_total;
    } t_out_item;

endpackage

/* src/cap_slider_position_to_led_duty_unit.sv */
// Path: an input beat passes the input register, then the result register;
//   the per-event logic sits between the two.
// Throughput: one beat per cycle while m_axis_tready stays high; a waiting result stalls it.
// Reset (i_rst_n low, synchronous): both stages empty, config back to
//   threshold 2048 / debounce on / limit 4, counters and duties zero,
//   latest samples all ones, history entry i holds i.
module cap_slider_position_to_led_duty_unit
    import csp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [3:0] sensor_pin, [15:4] sample_count
    input  logic [3:0]            s_axis_tuser,  // yes_touch, no_touch, timeout, overrun
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [87:0]           m_axis_tdata,  // duty_left, duty_middle, duty_right,
                                                 // position (6b each), timeout_total,
                                                 // overrun_total (32b each)
    output logic [1:0]            m_axis_tuser   // pwm_update, position_valid
);

    t_cfg      r_cfg;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item core_out;

    logic s_beat;
    logic advance;
    logic fire;

    // A stage moves whenever the result slot is empty or being drained.
    assign advance       = !r_out_vld || m_axis_tready;
    assign fire          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    // config registers; an index past the list is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_level     <= THRESH_RST;
            r_cfg.debounce_enable <= DBC_EN_RST;
            r_cfg.debounce_limit  <= DBC_LIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_THRESHOLD: r_cfg.touch_level     <= i_cfg_wdata[COUNT_W-1:0];
                CFG_DBC_EN:    r_cfg.debounce_enable <= i_cfg_wdata[0];
                CFG_DBC_LIMIT: r_cfg.debounce_limit  <= i_cfg_wdata[DBC_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_beat) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_beat) begin
            r_in.yes_touch    <= s_axis_tuser[0];
            r_in.no_touch     <= s_axis_tuser[1];
            r_in.timeout_flag <= s_axis_tuser[2];
            r_in.overrun_flag <= s_axis_tuser[3];
            r_in.sensor_pin   <= s_axis_tdata[3:0];
            r_in.sample_count <= s_axis_tdata[15:4];
        end
    end

    // all per-event state lives in the core and updates on fire
    csp_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_result (core_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.overrun_total, r_out.timeout_total, r_out.position,
                            r_out.duty_right, r_out.duty_middle, r_out.duty_left};
    assign m_axis_tuser  = {r_out.position_valid, r_out.pwm_update};

endmodule

/* src/csp_duty.sv */
module csp_duty
    import csp_pkg::*;
(
    input  t_count     i_cnt0,
    input  t_count     i_cnt1,
    input  t_count     i_cnt2,
    input  logic [1:0] i_big,
    output t_duty      o_pos,
    output t_duty      o_duty_left,
    output t_duty      o_duty_middle,
    output t_duty      o_duty_right
);

    logic signed [13:0] c0, c1, c2, raw;
    logic [DUTY_W-1:0]  pos;
    logic [6:0]         dbl;

    assign c0 = signed'({2'b00, i_cnt0});
    assign c1 = signed'({2'b00, i_cnt1});
    assign c2 = signed'({2'b00, i_cnt2});

    always_comb begin
        case (i_big)
            2'd0:    raw = POS_OFS_LEFT - (c0 - c1);
            2'd1:    raw = (c2 - c0) + POS_OFS_MID;
            default: raw = (c2 - c1) + POS_OFS_RIGHT;
        endcase
        if (raw < 14'sd0) begin
            pos = '0;
        end else if (raw > POS_MAX_S) begin
            pos = POS_MAX_S[DUTY_W-1:0];
        end else begin
            pos = raw[DUTY_W-1:0];
        end
    end

    assign dbl = {pos, 1'b0};

    always_comb begin
        if (pos <= POS_MID) begin
            o_duty_left   = DUTY_W'(DUTY_FULL - dbl);
            o_duty_middle = DUTY_W'(dbl);
            o_duty_right  = '0;
        end else begin
            o_duty_left   = '0;
            o_duty_middle = DUTY_W'(DUTY_DOUBLE - dbl);
            o_duty_right  = DUTY_W'(dbl - DUTY_FULL);
        end
    end

    assign o_pos = pos;

endmodule

/* src/csp_core.sv */
module csp_core
    import csp_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    t_count             r_latest [SENSOR_NUM];
    t_count             r_pcount [SENSOR_NUM];
    logic [1:0]         r_cur;
    logic [HIST_W-1:0]  r_hist [HISTORY_DEPTH];
    logic [PTR_W-1:0]   r_ptr;
    logic [DBC_W-1:0]   r_dbc;
    logic               r_dbc_done;
    logic               r_stable;
    logic [CNT32_W-1:0] r_tmo;
    logic [CNT32_W-1:0] r_ovr;
    t_duty              r_duty [SENSOR_NUM];

    t_count             n_latest [SENSOR_NUM];
    t_count             n_pcount [SENSOR_NUM];
    logic [1:0]         n_cur;
    logic [HIST_W-1:0]  n_hist [HISTORY_DEPTH];
    logic [PTR_W-1:0]   n_ptr;
    logic [DBC_W-1:0]   n_dbc;
    logic               n_dbc_done;
    logic               n_stable;
    logic [CNT32_W-1:0] n_tmo;
    logic [CNT32_W-1:0] n_ovr;
    t_duty              n_duty [SENSOR_NUM];

    t_count      upd_pcount [SENSOR_NUM];
    logic        pin_hit;
    logic [1:0]  big;
    logic        false_rel;
    logic        pending;
    logic [DBC_W-1:0] dbc_inc;
    logic        same;
    logic        update;
    logic        valid;
    t_duty       pos_calc, dl, dm, dr;
    t_duty       pos_out;

    assign pin_hit = (i_item.sensor_pin >= PIN_FIRST) && (i_item.sensor_pin <= PIN_LAST);
    assign n_cur   = pin_hit ? 2'(i_item.sensor_pin - PIN_FIRST) : r_cur;

    // counts with this touch written in; largest count, lowest index wins a tie
    always_comb begin
        upd_pcount        = r_pcount;
        upd_pcount[n_cur] = i_item.sample_count;
        big = 2'd0;
        if (upd_pcount[1] > upd_pcount[0]) begin
            big = 2'd1;
        end
        if (upd_pcount[2] > upd_pcount[big]) begin
            big = 2'd2;
        end
    end

    // position math runs on the already updated counts
    csp_duty u_duty (
        .i_cnt0        (upd_pcount[0]),
        .i_cnt1        (upd_pcount[1]),
        .i_cnt2        (upd_pcount[2]),
        .i_big         (big),
        .o_pos         (pos_calc),
        .o_duty_left   (dl),
        .o_duty_middle (dm),
        .o_duty_right  (dr)
    );

    always_comb begin
        for (int k = 0; k < SENSOR_NUM; k++) begin
            n_latest[k] = (pin_hit && (n_cur == 2'(k))) ? i_item.sample_count : r_latest[k];
        end

        false_rel = 1'b0;
        for (int k = 0; k < SENSOR_NUM; k++) begin
            if (n_latest[k] < i_cfg.touch_level) begin
                false_rel = 1'b1;
            end
        end
        false_rel = false_rel & i_item.no_touch;

        n_pcount   = r_pcount;
        n_hist     = r_hist;
        n_ptr      = r_ptr;
        n_dbc      = r_dbc;
        n_dbc_done = r_dbc_done;
        n_stable   = r_stable;
        n_tmo      = r_tmo;
        n_ovr      = r_ovr;
        n_duty     = r_duty;
        pending    = 1'b0;
        dbc_inc    = r_dbc + 1'b1;
        update     = 1'b0;
        valid      = 1'b0;
        pos_out    = '0;
        same       = 1'b1;

        if (i_item.yes_touch || i_item.no_touch) begin
            if (i_item.yes_touch || false_rel) begin
                if (i_cfg.debounce_enable && !r_dbc_done) begin
                    if (dbc_inc < i_cfg.debounce_limit) begin
                        pending = 1'b1;
                        n_dbc   = dbc_inc;
                    end else begin
                        n_dbc      = '0;
                        n_dbc_done = 1'b1;
                    end
                end
                if (!pending) begin
                    n_pcount[n_cur] = i_item.sample_count;
                    n_hist[r_ptr]   = {2'b00, big};
                    n_ptr           = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                    for (int k = 0; k + 1 < HISTORY_DEPTH; k++) begin
                        if (n_hist[k] != n_hist[k+1]) begin
                            same = 1'b0;
                        end
                    end
                    n_stable = same;
                    update   = 1'b1;
                    if (same) begin
                        n_duty[0] = dl;
                        n_duty[1] = dm;
                        n_duty[2] = dr;
                        pos_out   = pos_calc;
                        valid     = 1'b1;
                    end else begin
                        for (int k = 0; k < SENSOR_NUM; k++) begin
                            n_duty[k] = '0;
                        end
                    end
                end
            end else begin
                // release: every sensor back at or above threshold
                n_dbc_done = 1'b0;
                n_dbc      = '0;
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    n_hist[k] = HIST_W'(k);
                end
                n_stable = 1'b0;
                for (int k = 0; k < SENSOR_NUM; k++) begin
                    n_duty[k] = '0;
                end
                update = 1'b1;
            end
        end else if (i_item.timeout_flag) begin
            n_tmo = r_tmo + 1'b1;
        end else if (i_item.overrun_flag) begin
            n_ovr = r_ovr + 1'b1;
        end
    end

    always_comb begin
        o_result.pwm_update     = update;
        o_result.duty_left      = n_duty[0];
        o_result.duty_middle    = n_duty[1];
        o_result.duty_right     = n_duty[2];
        o_result.position       = pos_out;
        o_result.position_valid = valid;
        o_result.timeout_total  = n_tmo;
        o_result.overrun_total  = n_ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SENSOR_NUM; k++) begin
                r_latest[k] <= COUNT_MAX;
                r_pcount[k] <= '0;
                r_duty[k]   <= '0;
            end
            for (int k = 0; k < HISTORY_DEPTH; k++) begin
                r_hist[k] <= HIST_W'(k);
            end
            r_cur      <= '0;
            r_ptr      <= '0;
            r_dbc      <= '0;
            r_dbc_done <= 1'b0;
            r_stable   <= 1'b0;
            r_tmo      <= '0;
            r_ovr      <= '0;
        end else if (i_fire) begin
            r_latest   <= n_latest;
            r_pcount   <= n_pcount;
            r_duty     <= n_duty;
            r_hist     <= n_hist;
            r_cur      <= n_cur;
            r_ptr      <= n_ptr;
            r_dbc      <= n_dbc;
            r_dbc_done <= n_dbc_done;
            r_stable   <= n_stable;
            r_tmo      <= n_tmo;
            r_ovr      <= n_ovr;
        end
    end

endmodule

/* tb/sv/tb_cap_slider_position_to_led_duty_unit.sv */
`timescale 1ns / 1ps

module tb_cap_slider_position_to_led_duty_unit;
    import csp_pkg::*;

    localparam int HIST_DEPTH    = 4;
    localparam int PHASES        = 7;
    localparam int PHASE_EVENTS  = 125;

    // tuser bit of each input flag, lowest first
    localparam logic [3:0] FLG_NONE = 4'b0000;
    localparam logic [3:0] FLG_YES  = 4'b0001;
    localparam logic [3:0] FLG_NO   = 4'b0010;
    localparam logic [3:0] FLG_TMO  = 4'b0100;
    localparam logic [3:0] FLG_OVR  = 4'b1000;
    localparam logic [3:0] FLG_ALL  = 4'b1111;

    // Fixed results for the directed rows, packed as
    // {pwm_update, left, middle, right, position, valid, timeouts, overruns}
    localparam t_out_item RES_NONE  = '0;
    localparam t_out_item RES_REL_0 = {1'b1, 24'd0, 1'b0, 32'd0, 32'd0};
    localparam t_out_item RES_T1    = {1'b0, 24'd0, 1'b0, 32'd1, 32'd0};
    localparam t_out_item RES_T1O1  = {1'b0, 24'd0, 1'b0, 32'd1, 32'd1};
    localparam t_out_item RES_HOLD  = {1'b0, 24'd0, 1'b0, 32'd2, 32'd1};
    localparam t_out_item RES_CLEAR = {1'b1, 24'd0, 1'b0, 32'd2, 32'd1};

    typedef struct packed {
        logic [3:0]         flags;
        logic [PIN_W-1:0]   pin;
        logic [COUNT_W-1:0] cnt;
        logic               fixed;  // 1: res below is the expected beat
        t_out_item          res;
    } t_dir_row;

    typedef struct {
        bit        fixed;
        t_out_item res;
    } t_pinned;

    // Directed walk, reset settings (threshold 2048, debounce on, limit 4).
    // Counters only move in rows 1..3, so later fixed rows carry 2 / 1.
    localparam int DIR_ROWS = 23;
    localparam t_dir_row STEPS [DIR_ROWS] = '{
        {FLG_NO,          4'd6,  12'hFFF, 1'b1, RES_REL_0},  // release, all counts high
        {FLG_TMO,         4'd0,  12'h000, 1'b1, RES_T1},     // timeout, unmapped pin
        {FLG_OVR,         4'd15, 12'hFFF, 1'b1, RES_T1O1},   // overrun, top pin
        {FLG_TMO|FLG_OVR, 4'd5,  12'h800, 1'b1, RES_HOLD},   // timeout wins over overrun
        {FLG_YES,         4'd7,  12'h000, 1'b1, RES_HOLD},   // debounce 1 of 4
        {FLG_YES|FLG_TMO, 4'd8,  12'h010, 1'b1, RES_HOLD},   // touch masks timeout
        {FLG_YES|FLG_OVR, 4'd6,  12'h020, 1'b1, RES_HOLD},   // touch masks overrun
        {FLG_YES,         4'd6,  12'h000, 1'b1, RES_CLEAR},  // debounce done, history mixed
        {FLG_YES,         4'd7,  12'h040, 1'b0, RES_NONE},
        {FLG_YES,         4'd8,  12'h030, 1'b0, RES_NONE},
        {FLG_YES,         4'd6,  12'h038, 1'b0, RES_NONE},
        {FLG_YES,         4'd7,  12'h040, 1'b0, RES_NONE},   // history settles on middle
        {FLG_NO,          4'd7,  12'h044, 1'b0, RES_NONE},   // false release
        {FLG_YES,         4'd3,  12'hFFF, 1'b0, RES_NONE},   // unmapped pin still writes
        {FLG_YES,         4'd8,  12'hFFF, 1'b0, RES_NONE},   // tie, clamp at 60
        {FLG_YES,         4'd6,  12'hFFF, 1'b0, RES_NONE},   // three-way tie
        {FLG_YES|FLG_NO,  4'd6,  12'hFFF, 1'b0, RES_NONE},   // both touch flags
        {FLG_ALL,         4'd6,  12'hFFF, 1'b0, RES_NONE},
        {FLG_YES,         4'd7,  12'h000, 1'b0, RES_NONE},   // clamp at 0
        {FLG_NONE,        4'd7,  12'hFFF, 1'b0, RES_NONE},   // no event, duties repeat
        {FLG_NONE,        4'd8,  12'hFFF, 1'b0, RES_NONE},
        {FLG_NO,          4'd8,  12'h800, 1'b1, RES_CLEAR},  // release, count at threshold
        {FLG_NO,          4'd8,  12'h7FF, 1'b1, RES_HOLD}    // just below: debounce restarts
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // [3:0] sensor_pin, [15:4] sample_count
    logic [3:0]            s_axis_tuser = '0;   // yes_touch, no_touch, timeout, overrun
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [87:0]           m_axis_tdata;        // left, middle, right, position,
                                                // timeout_total, overrun_total
    logic [1:0]            m_axis_tuser;        // pwm_update, position_valid

    cap_slider_position_to_led_duty_unit #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Slider predictor: its own copy of settings and state
    // ------------------------------------------------------------------
    t_cfg               cfg_m;
    t_count             raw_cnt  [SENSOR_NUM];  // latest count per sensor
    t_count             pos_cnt  [SENSOR_NUM];  // counts used for position
    logic [1:0]         sel_sensor;
    logic [HIST_W-1:0]  lead_hist [HIST_DEPTH]; // which sensor led, per touch
    int                 hist_wr;
    logic [DBC_W-1:0]   dbc_cnt;
    logic               dbc_done;
    logic [CNT32_W-1:0] tmo_tot;
    logic [CNT32_W-1:0] ovr_tot;
    t_duty              duty_q   [SENSOR_NUM];

    t_out_item results_due[$];  // duty beats still to come out
    t_pinned   pinned_q[$];     // per sent beat: fixed result or none

    int fail_count = 0;
    int events_sent = 0;
    int results_seen = 0;
    int duty_writes = 0;
    int stable_hits = 0;
    int releases = 0;
    int settings_used = 1;
    int src_calm = 0;
    bit src_held = 1'b0;        // tvalid left high after the last beat

    function automatic t_in_item make_event(input logic [3:0] flags,
                                            input logic [PIN_W-1:0] pin,
                                            input t_count cnt);
        t_in_item ev;
        ev.yes_touch    = |(flags & FLG_YES);
        ev.no_touch     = |(flags & FLG_NO);
        ev.timeout_flag = |(flags & FLG_TMO);
        ev.overrun_flag = |(flags & FLG_OVR);
        ev.sensor_pin   = pin;
        ev.sample_count = cnt;
        return ev;
    endfunction

    task automatic clear_history();
        for (int i = 0; i < HIST_DEPTH; i++) lead_hist[i] = HIST_W'(i);
    endtask

    task automatic slider_reset();
        cfg_m.touch_level     = THRESH_RST;
        cfg_m.debounce_enable = DBC_EN_RST;
        cfg_m.debounce_limit  = DBC_LIM_RST;
        for (int i = 0; i < SENSOR_NUM; i++) begin
            raw_cnt[i] = COUNT_MAX;
            pos_cnt[i] = '0;
            duty_q[i]  = '0;
        end
        sel_sensor = '0;
        clear_history();
        hist_wr  = 0;
        dbc_cnt  = '0;
        dbc_done = 1'b0;
        tmo_tot  = '0;
        ovr_tot  = '0;
    endtask

    task automatic slider_predict(input t_in_item ev, output t_out_item res);
        bit held;
        bit pending;
        bit same;
        int lead;
        int c0, c1, c2, s;
        res = '0;
        if (ev.sensor_pin >= PIN_FIRST && ev.sensor_pin <= PIN_LAST) begin
            sel_sensor = 2'(ev.sensor_pin - PIN_FIRST);
            raw_cnt[sel_sensor] = ev.sample_count;
        end
        if (ev.yes_touch || ev.no_touch) begin
            // a no-touch with any sensor still under threshold counts as a touch
            held = 1'b0;
            if (ev.no_touch)
                for (int i = 0; i < SENSOR_NUM; i++)
                    if (raw_cnt[i] < cfg_m.touch_level) held = 1'b1;
            if (ev.yes_touch || held) begin
                pending = 1'b0;
                if (cfg_m.debounce_enable && !dbc_done) begin
                    dbc_cnt = dbc_cnt + 1'b1;
                    if (dbc_cnt < cfg_m.debounce_limit) begin
                        pending = 1'b1;
                    end else begin
                        dbc_cnt  = '0;
                        dbc_done = 1'b1;
                    end
                end
                if (!pending) begin
                    pos_cnt[sel_sensor] = ev.sample_count;
                    lead = 0;
                    for (int i = 1; i < SENSOR_NUM; i++)
                        if (pos_cnt[i] > pos_cnt[lead]) lead = i;
                    lead_hist[hist_wr] = HIST_W'(lead);
                    hist_wr = (hist_wr + 1) % HIST_DEPTH;
                    same = 1'b1;
                    for (int i = 0; i + 1 < HIST_DEPTH; i++)
                        if (lead_hist[i] != lead_hist[i + 1]) same = 1'b0;
                    if (same) begin
                        c0 = pos_cnt[0];
                        c1 = pos_cnt[1];
                        c2 = pos_cnt[2];
                        if (lead == 0)      s = 10 - (c0 - c1);
                        else if (lead == 1) s = (c2 - c0) + 30;
                        else                s = (c2 - c1) + 50;
                        if (s < 0)       s = 0;
                        else if (s > 60) s = 60;
                        if (s <= 30) begin
                            duty_q[0] = DUTY_W'(60 - 2 * s);
                            duty_q[1] = DUTY_W'(2 * s);
                            duty_q[2] = '0;
                        end else begin
                            duty_q[0] = '0;
                            duty_q[1] = DUTY_W'(120 - 2 * s);
                            duty_q[2] = DUTY_W'(2 * s - 60);
                        end
                        res.position       = DUTY_W'(s);
                        res.position_valid = 1'b1;
                        stable_hits++;
                    end else begin
                        for (int i = 0; i < SENSOR_NUM; i++) duty_q[i] = '0;
                    end
                    res.pwm_update = 1'b1;
                end
            end else begin
                // real release: drop debounce and history, blank the LEDs
                dbc_done = 1'b0;
                dbc_cnt  = '0;
                clear_history();
                for (int i = 0; i < SENSOR_NUM; i++) duty_q[i] = '0;
                res.pwm_update = 1'b1;
                releases++;
            end
        end else if (ev.timeout_flag) begin
            tmo_tot = tmo_tot + 1'b1;
        end else if (ev.overrun_flag) begin
            ovr_tot = ovr_tot + 1'b1;
        end
        if (res.pwm_update) duty_writes++;
        res.duty_left     = duty_q[0];
        res.duty_middle   = duty_q[1];
        res.duty_right    = duty_q[2];
        res.timeout_total = tmo_tot;
        res.overrun_total = ovr_tot;
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(9, 40);
    endfunction

    // result side back-pressure, with calm stretches of its own
    int stall_left = 0;
    int sink_calm = 0;
    always @(posedge i_clk) begin
        if (sink_calm > 0) begin
            sink_calm <= sink_calm - 1;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 3) sink_calm <= $urandom_range(20, 80);
            else stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Input beat monitor: predict on every accepted event
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_in_item  ev;
        t_out_item res;
        t_pinned   p;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            ev = make_event(s_axis_tuser, s_axis_tdata[PIN_W-1:0],
                            s_axis_tdata[PIN_W +: COUNT_W]);
            slider_predict(ev, res);
            p = pinned_q.pop_front();
            results_due.push_back(p.fixed ? p.res : res);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result beat checker, field by field against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing outstanding");
                fail_count++;
            end else begin
                want = results_due.pop_front();
                results_seen++;
                check_field("pwm_update",     want.pwm_update,     m_axis_tuser[0]);
                check_field("position_valid", want.position_valid, m_axis_tuser[1]);
                check_field("duty_left",      want.duty_left,      m_axis_tdata[5:0]);
                check_field("duty_middle",    want.duty_middle,    m_axis_tdata[11:6]);
                check_field("duty_right",     want.duty_right,     m_axis_tdata[17:12]);
                check_field("position",       want.position,       m_axis_tdata[23:18]);
                check_field("timeout_total",  want.timeout_total,  m_axis_tdata[55:24]);
                check_field("overrun_total",  want.overrun_total,  m_axis_tdata[87:56]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic drive_event(input t_in_item ev, input bit fixed, input t_out_item res);
        t_pinned p;
        p.fixed = fixed;
        p.res   = res;
        pinned_q.push_back(p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.sample_count, ev.sensor_pin};
        s_axis_tuser  <= {ev.overrun_flag, ev.timeout_flag, ev.no_touch, ev.yes_touch};
        src_held = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        events_sent++;
    endtask

    task automatic src_pause();
        int n;
        if (src_calm > 0) begin
            src_calm--;
            n = 0;
        end else begin
            n = idle_len();
            if ($urandom_range(0, 99) < 3) src_calm = $urandom_range(20, 80);
        end
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            src_held = 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(input t_in_item ev);
        drive_event(ev, 1'b0, RES_NONE);
        src_pause();
    endtask

    // stop sending, wait for every result, then let the two stages settle
    task automatic wait_drained();
        if (src_held) begin
            s_axis_tvalid <= 1'b0;
            src_held = 1'b0;
        end
        @(posedge i_clk);
        while (results_seen != events_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // all three registers in one burst; the block is idle here
    task automatic apply_settings(input t_count thr, input logic en,
                                  input logic [DBC_W-1:0] lim);
        cfg_m.touch_level     = thr;
        cfg_m.debounce_enable = en;
        cfg_m.debounce_limit  = lim;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_THRESHOLD;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_DBC_EN;
        i_cfg_wdata <= CFG_DATA_W'(en);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_DBC_LIMIT;
        i_cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // A finger held on the slider: counts near a common base so positions
    // land inside 0..60 most of the time, spilling over now and then.
    task automatic swipe();
        int base, steps, s, v, d, r;
        int offs [SENSOR_NUM];
        logic [3:0]       fl;
        logic [PIN_W-1:0] pin;
        base  = $urandom_range(0, 4000);
        steps = $urandom_range(3, 14);
        for (int i = 0; i < SENSOR_NUM; i++) offs[i] = $urandom_range(0, 90);
        for (int k = 0; k < steps; k++) begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : k % SENSOR_NUM;
            d = $urandom_range(0, 8);
            offs[s] = offs[s] + d - 4;
            if (offs[s] < 0) offs[s] = 0;
            v = base + offs[s] + $urandom_range(0, 6);
            if (v > COUNT_MAX) v = COUNT_MAX;
            if ($urandom_range(0, 9) == 0) v = $urandom_range(0, COUNT_MAX);
            r  = $urandom_range(0, 99);
            fl = FLG_YES;
            if (r < 12)      fl = FLG_NO;
            else if (r < 16) fl = FLG_YES | FLG_NO;
            else if (r < 24) begin
                if ($urandom_range(0, 1)) fl = fl | FLG_TMO;
                if ($urandom_range(0, 1)) fl = fl | FLG_OVR;
            end
            pin = ($urandom_range(0, 19) == 0) ? PIN_W'($urandom_range(0, 15))
                                                : PIN_W'(PIN_FIRST + s);
            send(make_event(fl, pin, t_count'(v)));
        end
    endtask

    // Lift the finger: raise every sensor, then report no-touch. A spoiled
    // lift leaves one sensor under threshold so it reads as a false release.
    task automatic lift(input bit clean);
        int spoiled, thr, v;
        logic [3:0] fl;
        thr = cfg_m.touch_level;
        spoiled = clean ? -1 : $urandom_range(0, 2);
        for (int s = 0; s < SENSOR_NUM; s++) begin
            if (s == spoiled && thr > 0) v = $urandom_range(0, thr - 1);
            else v = $urandom_range(thr, COUNT_MAX);
            fl = FLG_NONE;
            if ($urandom_range(0, 3) == 0) fl = fl | FLG_TMO;
            if ($urandom_range(0, 3) == 0) fl = fl | FLG_OVR;
            send(make_event(fl, PIN_W'(PIN_FIRST + s), t_count'(v)));
        end
        send(make_event(FLG_NO, PIN_W'(PIN_FIRST + $urandom_range(0, 2)),
                        t_count'($urandom_range(thr, COUNT_MAX))));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase_end;
        int pick;
        slider_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            drive_event(make_event(STEPS[k].flags, STEPS[k].pin, STEPS[k].cnt),
                        STEPS[k].fixed, STEPS[k].res);
            src_pause();
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: apply_settings(12'h800, 1'b1, 8'd1);
                1: apply_settings(COUNT_MAX, 1'b0, 8'd0);
                2: apply_settings(12'h000, 1'b1, 8'd0);
                3: apply_settings(t_count'($urandom_range(1, 4094)), 1'b1, 8'hFF);
                4: apply_settings(t_count'($urandom_range(1, 4094)), 1'b0,
                                  DBC_W'($urandom_range(2, 8)));
                5: apply_settings(12'h900, 1'b1, 8'd3);
                default: apply_settings(t_count'($urandom), 1'b1,
                                        DBC_W'($urandom_range(1, 6)));
            endcase
            phase_end = events_sent + PHASE_EVENTS;
            while (events_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) swipe();
                else if (pick < 80) lift($urandom_range(0, 3) != 0);
                else begin
                    // raw noise: any flags, any pin, any count
                    repeat ($urandom_range(1, 4))
                        send(make_event(4'($urandom), PIN_W'($urandom), t_count'($urandom)));
                end
            end
        end
        wait_drained();

        if (results_due.size() != 0) begin
            $error("%0d duty beats never arrived", results_due.size());
            fail_count++;
        end
        $display("%0d touch events under %0d register settings: %0d duty writes,",
                 events_sent, settings_used, duty_writes);
        $display("%0d stable slider positions, %0d finger releases", stable_hits, releases);
        if (fail_count == 0) begin
            $display("tb_cap_slider_position_to_led_duty_unit OK");
        end else begin
            $display("tb_cap_slider_position_to_led_duty_unit NOT OK");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_cap_slider_position_to_led_duty_unit NOT OK");
        $finish;
    end

endmodule

/* sim.f */
src/csp_pkg.sv
src/csp_duty.sv
src/csp_core.sv
src/cap_slider_position_to_led_duty_unit.sv
tb/sv/tb_cap_slider_position_to_led_duty_unit.sv
